>>> design/mbps_pkg.sv
// Package with shared constants, command codes and the cell control type.
package mbps_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 32;
   // active length runs 1..MAX_PATTERN
   localparam int ACT_W       = $clog2(MAX_PATTERN + 1);

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_SCAN = 1'b1
   } cmd_type;

   typedef struct packed {
      logic              load;
      logic              scan;
      logic              clear;
      logic [BYTE_W-1:0] data_byte;
      logic              care;
   } cell_ctl_type;

endpackage

>>> design/mbps_cell.sv
// One pattern position: stored byte, care flag and partial-match bit.
module mbps_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mbps_pkg::cell_ctl_type ctl,
   input  logic                  prev_hit,
   output logic                  hit,
   output logic                  cand
);

   logic [mbps_pkg::BYTE_W-1:0] pat_ff;
   logic [mbps_pkg::BYTE_W-1:0] pat_in;
   logic                        care_ff;
   logic                        care_in;
   logic                        hit_ff;
   logic                        hit_in;

   // a wildcard position matches any byte
   assign cand = prev_hit && (!care_ff || (pat_ff == ctl.data_byte));
   assign hit  = hit_ff;

   always_comb begin
      pat_in  = pat_ff;
      care_in = care_ff;
      if (ctl.load) begin
         pat_in  = ctl.data_byte;
         care_in = ctl.care;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (ctl.scan) begin
         hit_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         care_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         care_ff <= care_in;
         hit_ff  <= hit_in;
      end
   end

endmodule

>>> design/masked_byte_pattern_search.sv
// Top level: masked byte pattern search over a row of compare cells.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, entry_index, data_byte, care, last
//   rsp      out        rsp_valid/rsp_stall  found, match_offset
//   csr      in         csr_valid/csr_ready  pattern_length
//
// One beat per cycle on req while req_stall is low; every pattern position compares
// in its own cell in the cycle the region byte is accepted, and the result lands in
// the output register on the next edge. A match or end-of-region result shows in the
// cycle after the beat that caused it. Reset clears care flags, partial-match bits,
// position and the output valid; pattern bytes stay undefined until loaded.
// req stalls only while a result sits in the output register and rsp stalls.
module masked_byte_pattern_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [mbps_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [mbps_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_care,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [mbps_pkg::OFFSET_W-1:0]  rsp_match_offset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mbps_pkg::LEN_W-1:0]     csr_pattern_length
);

   localparam int NP = mbps_pkg::MAX_PATTERN;

   logic [mbps_pkg::LEN_W-1:0]    len_ff;
   logic [mbps_pkg::LEN_W-1:0]    len_in;
   logic [mbps_pkg::ACT_W-1:0]    act_len;
   logic [mbps_pkg::OFFSET_W-1:0] pos_ff;
   logic [mbps_pkg::OFFSET_W-1:0] pos_in;
   logic                          reported_ff;
   logic                          reported_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_found_ff;
   logic                          rsp_found_in;
   logic [mbps_pkg::OFFSET_W-1:0] rsp_offset_ff;
   logic [mbps_pkg::OFFSET_W-1:0] rsp_offset_in;

   logic                          req_accept;
   logic                          load_beat;
   logic                          scan_beat;
   logic                          scan_live;
   logic                          tail_hit;
   logic                          emit_match;
   logic                          emit_miss;
   logic [NP-1:0]                 hit;
   logic [NP-1:0]                 cand;
   logic [NP-1:0]                 prev_hit;
   logic [NP-1:0]                 tail_oh;
   mbps_pkg::cell_ctl_type        cell_ctl [NP];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign load_beat  = req_accept && (req_command == mbps_pkg::CMD_LOAD);
   assign scan_beat  = req_accept && (req_command == mbps_pkg::CMD_SCAN);
   assign scan_live  = scan_beat && !reported_ff;
   assign csr_ready  = 1'b1;

   // clamp the length register to 1..MAX_PATTERN
   always_comb begin
      if (len_ff == '0) begin
         act_len = mbps_pkg::ACT_W'(1);
      end else if (int'(len_ff) > NP) begin
         act_len = mbps_pkg::ACT_W'(NP);
      end else begin
         act_len = mbps_pkg::ACT_W'(len_ff);
      end
   end

   assign prev_hit[0] = 1'b1;

   for (genvar k = 0; k < NP; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign prev_hit[k] = hit[k-1];
      end
      assign tail_oh[k]             = (mbps_pkg::ACT_W'(k + 1) == act_len);
      assign cell_ctl[k].load       = load_beat && (32'(req_entry_index) == 32'(k));
      // positions at or past the active length hold their bit
      assign cell_ctl[k].scan       = scan_live && (mbps_pkg::ACT_W'(k) < act_len);
      assign cell_ctl[k].clear      = scan_beat && req_last;
      assign cell_ctl[k].data_byte  = req_data_byte;
      assign cell_ctl[k].care       = req_care;

      mbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl[k]),
         .prev_hit (prev_hit[k]),
         .hit      (hit[k]),
         .cand     (cand[k])
      );
   end

   assign tail_hit   = |(cand & tail_oh);
   assign emit_match = scan_live && tail_hit;
   assign emit_miss  = scan_live && !tail_hit && req_last;

   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = csr_pattern_length;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (scan_beat) begin
         if (req_last) begin
            pos_in      = '0;
            reported_in = 1'b0;
         end else begin
            pos_in = pos_ff + mbps_pkg::OFFSET_W'(1);
            if (emit_match) begin
               reported_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (emit_match || emit_miss) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = emit_match;
         rsp_offset_in = emit_match ?
            pos_ff - (mbps_pkg::OFFSET_W'(act_len) - mbps_pkg::OFFSET_W'(1)) : '0;
      end else if (!rsp_stall) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= mbps_pkg::LEN_W'(1);
         pos_ff       <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   a_miss_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_offset_ff == '0)
      else $error("not-found result carries a nonzero offset");

   a_region_end_clears: assert property (@(posedge clock) disable iff (reset)
      scan_beat && req_last |=> pos_ff == '0 && !reported_ff)
      else $error("scan state not cleared after last byte");

   a_match_sticks: assert property (@(posedge clock) disable iff (reset)
      emit_match && !req_last |=> reported_ff && rsp_valid_ff && rsp_found_ff)
      else $error("match not recorded");

   a_load_keeps_scan: assert property (@(posedge clock) disable iff (reset)
      load_beat |=> pos_ff == $past(pos_ff) && reported_ff == $past(reported_ff))
      else $error("pattern load disturbed the scan state");

endmodule
